@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// bptc_pkg
// shared widths, register codes and inter-stage types of the compensation
// pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

    localparam int RAW_W         = 24;   // width of each raw field on the bus
    localparam int ADC_BITS_DEF  = 24;
    localparam int IN_TDATA_W    = 2 * RAW_W;
    localparam int CAL_W         = 16;
    localparam int CFG_IDX_W     = 3;

    // calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

    // internal widths
    localparam int DT_W    = 25;  // dT, signed
    localparam int DTEMP_W = 19;  // TEMP - 2000 before second order, signed
    localparam int E_W     = 20;  // TEMP + 1500, signed
    localparam int T2_W    = 17;  // T2, unsigned
    localparam int FO_W    = 36;  // first-order OFF and SENS, signed
    localparam int SQ_W    = 35;  // squared temperature terms, unsigned
    localparam int CORR_W  = 38;  // OFF2 and SENS2, unsigned
    localparam int TEMP_W  = 21;  // final TEMP before limiting, signed
    localparam int FIN_W   = 40;  // final OFF and SENS, signed

    // output fields
    localparam int TOUT_W      = 15;
    localparam int POUT_W      = 17;
    localparam int OUT_TDATA_W = TOUT_W + POUT_W;

    // arithmetic constants
    localparam int TEMP_REF      = 2000;
    localparam int TEMP_VLOW_OFS = 3500;   // threshold TEMP = -1500, i.e. 35.00 C below 20.00 C
    localparam int TEMP_MIN      = -4000;
    localparam int TEMP_MAX      = 8500;
    localparam int PRES_MAX      = 120000;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // first-order result
    typedef struct packed {
        logic signed [DTEMP_W-1:0] dtemp;
        logic signed [E_W-1:0]     e;
        logic        [T2_W-1:0]    t2;
        logic signed [FO_W-1:0]    off;
        logic signed [FO_W-1:0]    sens;
    } t_fo;

    // second-order corrected result
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [FIN_W-1:0]  off;
        logic signed [FIN_W-1:0]  sens;
    } t_so;

endpackage

`default_nettype wire

@@ design/bptc_cal_regs.sv @@
// ----------------------------------------------------------------------------
// bptc_cal_regs
// calibration word register file, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_cal_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bptc_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [bptc_pkg::CAL_W-1:0]     i_data,
    output bptc_pkg::t_cal                 o_cal
);
    import bptc_pkg::*;

    t_cal r_cal;
    t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_valid) begin
            unique case (i_index)
                REG_C1:  n_cal.c1 = i_data;
                REG_C2:  n_cal.c2 = i_data;
                REG_C3:  n_cal.c3 = i_data;
                REG_C4:  n_cal.c4 = i_data;
                REG_C5:  n_cal.c5 = i_data;
                REG_C6:  n_cal.c6 = i_data;
                default: n_cal = r_cal;   // index beyond the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_ready = 1'b1;
    assign o_cal   = r_cal;

endmodule

`default_nettype wire

@@ design/bptc_first_order.sv @@
// ----------------------------------------------------------------------------
// bptc_first_order
// three stages: dT, calibration products, first-order TEMP / OFF / SENS / T2
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_first_order #(
    parameter int ADC_BITS = bptc_pkg::ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bptc_pkg::t_cal      i_cal,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ADC_BITS-1:0] i_d1,
    input  logic [ADC_BITS-1:0] i_d2,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ADC_BITS-1:0] o_d1,
    output bptc_pkg::t_fo       o_fo
);
    import bptc_pkg::*;

    localparam int MP_W    = DT_W + CAL_W + 1;  // dT times a calibration word
    localparam int SQF_W   = 2 * DT_W;
    localparam int SQV_W   = 2 * DT_W - 2;      // dT^2 is positive and below 2^48
    localparam int T_SH    = 23;
    localparam int OFF_SH  = 7;
    localparam int SENS_SH = 8;
    localparam int T2_SH   = 31;

    logic [2:0] r_v;
    logic [2:0] en;

    // stage 1
    logic [ADC_BITS-1:0]    r_d1_s1;
    logic signed [DT_W-1:0] r_dt;
    logic signed [DT_W-1:0] n_dt;

    // stage 2
    logic [ADC_BITS-1:0]     r_d1_s2;
    logic signed [MP_W-1:0]  r_mt, r_moff, r_msens;
    logic signed [MP_W-1:0]  n_mt, n_moff, n_msens;
    logic signed [SQF_W-1:0] n_sq;
    logic [SQV_W-1:0]        r_sq;

    // stage 3
    logic [ADC_BITS-1:0]       r_d1_s3;
    t_fo                       r_fo;
    t_fo                       n_fo;
    logic signed [DTEMP_W-1:0] s3_dtemp;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // dT = D2 - C5 * 256
    assign n_dt = $signed({1'b0, (DT_W-1)'(i_d2)}) - $signed({1'b0, i_cal.c5, 8'd0});

    assign n_mt    = MP_W'(r_dt) * MP_W'($signed({1'b0, i_cal.c6}));
    assign n_moff  = MP_W'(r_dt) * MP_W'($signed({1'b0, i_cal.c4}));
    assign n_msens = MP_W'(r_dt) * MP_W'($signed({1'b0, i_cal.c3}));
    assign n_sq    = SQF_W'(r_dt) * SQF_W'(r_dt);

    always_comb begin
        s3_dtemp   = $signed(r_mt[MP_W-1:T_SH]);
        n_fo.dtemp = s3_dtemp;
        n_fo.e     = E_W'(s3_dtemp) + E_W'(TEMP_VLOW_OFS);
        n_fo.t2    = r_sq[SQV_W-1:T2_SH];
        n_fo.off   = $signed({4'd0, i_cal.c2, 16'd0})
                   + FO_W'($signed(r_moff[MP_W-1:OFF_SH]));
        n_fo.sens  = $signed({5'd0, i_cal.c1, 15'd0})
                   + FO_W'($signed(r_msens[MP_W-1:SENS_SH]));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d1_s1 <= i_d1;
            r_dt    <= n_dt;
        end
        if (en[1]) begin
            r_d1_s2 <= r_d1_s1;
            r_mt    <= n_mt;
            r_moff  <= n_moff;
            r_msens <= n_msens;
            r_sq    <= n_sq[SQV_W-1:0];
        end
        if (en[2]) begin
            r_d1_s3 <= r_d1_s2;
            r_fo    <= n_fo;
        end
    end

    assign o_d1 = r_d1_s3;
    assign o_fo = r_fo;

endmodule

`default_nettype wire

@@ design/bptc_second_order.sv @@
// ----------------------------------------------------------------------------
// bptc_second_order
// three stages: squared temperature terms, T2 / OFF2 / SENS2, corrected values
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_second_order #(
    parameter int ADC_BITS = bptc_pkg::ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ADC_BITS-1:0] i_d1,
    input  bptc_pkg::t_fo       i_fo,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ADC_BITS-1:0] o_d1,
    output bptc_pkg::t_so       o_so
);
    import bptc_pkg::*;

    localparam int SQA_W = 2 * DTEMP_W;
    localparam int SQB_W = 2 * E_W;

    logic [2:0] r_v;
    logic [2:0] en;

    // stage 4
    logic [ADC_BITS-1:0]       r_d1_s4;
    logic signed [DTEMP_W-1:0] r_dtemp;
    logic [T2_W-1:0]           r_t2;
    logic signed [FO_W-1:0]    r_off_s4, r_sens_s4;
    logic                      r_low, r_vlow;
    logic [SQ_W-1:0]           r_a, r_b;
    logic signed [SQA_W-1:0]   n_a;
    logic signed [SQB_W-1:0]   n_b;

    // stage 5
    logic [ADC_BITS-1:0]      r_d1_s5;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [FO_W-1:0]   r_off_s5, r_sens_s5;
    logic [CORR_W-1:0]        r_off2, r_sens2;
    logic [CORR_W-1:0]        a5, b7, b11;
    logic [CORR_W-1:0]        n_off2, n_sens2;
    logic [T2_W-1:0]          t2_g;
    logic signed [TEMP_W-1:0] n_temp;

    // stage 6
    logic [ADC_BITS-1:0] r_d1_s6;
    t_so                 r_so;
    t_so                 n_so;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    assign n_a = SQA_W'(i_fo.dtemp) * SQA_W'(i_fo.dtemp);
    assign n_b = SQB_W'(i_fo.e) * SQB_W'(i_fo.e);

    // constant multiples by shift and add, then gate on the temperature bands
    always_comb begin
        a5      = {3'd0, r_a} + {1'b0, r_a, 2'd0};
        b7      = {r_b, 3'd0} - {3'd0, r_b};
        b11     = {r_b, 3'd0} + {2'd0, r_b, 1'b0} + {3'd0, r_b};
        n_off2  = (r_low ? {1'b0, a5[CORR_W-1:1]} : '0)
                + ((r_low && r_vlow) ? b7 : '0);
        n_sens2 = (r_low ? {2'd0, a5[CORR_W-1:2]} : '0)
                + ((r_low && r_vlow) ? {1'b0, b11[CORR_W-1:1]} : '0);
        t2_g    = r_low ? r_t2 : '0;
        n_temp  = TEMP_W'(r_dtemp) + TEMP_W'(TEMP_REF)
                - $signed({{(TEMP_W-T2_W){1'b0}}, t2_g});
    end

    always_comb begin
        n_so.temp = r_temp;
        n_so.off  = FIN_W'(r_off_s5) - $signed({{(FIN_W-CORR_W){1'b0}}, r_off2});
        n_so.sens = FIN_W'(r_sens_s5) - $signed({{(FIN_W-CORR_W){1'b0}}, r_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d1_s4   <= i_d1;
            r_dtemp   <= i_fo.dtemp;
            r_t2      <= i_fo.t2;
            r_off_s4  <= i_fo.off;
            r_sens_s4 <= i_fo.sens;
            r_low     <= i_fo.dtemp[DTEMP_W-1];
            r_vlow    <= i_fo.e[E_W-1];
            r_a       <= n_a[SQ_W-1:0];
            r_b       <= n_b[SQ_W-1:0];
        end
        if (en[1]) begin
            r_d1_s5   <= r_d1_s4;
            r_temp    <= n_temp;
            r_off_s5  <= r_off_s4;
            r_sens_s5 <= r_sens_s4;
            r_off2    <= n_off2;
            r_sens2   <= n_sens2;
        end
        if (en[2]) begin
            r_d1_s6 <= r_d1_s5;
            r_so    <= n_so;
        end
    end

    assign o_d1 = r_d1_s6;
    assign o_so = r_so;

endmodule

`default_nettype wire

@@ design/bptc_pressure.sv @@
// ----------------------------------------------------------------------------
// bptc_pressure
// three stages: split D1 * SENS products, recombine and shift, subtract OFF
// and limit both outputs into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_pressure #(
    parameter int ADC_BITS = bptc_pkg::ADC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ADC_BITS-1:0]           i_d1,
    input  bptc_pkg::t_so                 i_so,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bptc_pkg::TOUT_W-1:0]   o_temp,
    output logic [bptc_pkg::POUT_W-1:0]   o_pres,
    output logic                          o_clamp
);
    import bptc_pkg::*;

    localparam int SPLIT   = 20;
    localparam int PL_W    = ADC_BITS + SPLIT;
    localparam int PH_W    = ADC_BITS + 1 + FIN_W - SPLIT;
    localparam int PROD_W  = PH_W + SPLIT + 1;
    localparam int P_SH    = 21;
    localparam int Q1_W    = PROD_W - P_SH;
    localparam int Q_W     = ((Q1_W > FIN_W) ? Q1_W : FIN_W) + 1;
    localparam int Q_SH    = 15;
    localparam int P_W     = Q_W - Q_SH;

    logic [2:0] r_v;
    logic [2:0] en;

    // stage 7
    logic [PL_W-1:0]          r_pl, n_pl;
    logic signed [PH_W-1:0]   r_ph, n_ph;
    logic signed [FIN_W-1:0]  r_off_s7;
    logic signed [TEMP_W-1:0] r_temp_s7;

    // stage 8
    logic signed [PROD_W-1:0] s8_hi, s8_lo, s8_prod;
    logic signed [Q1_W-1:0]   r_q1;
    logic signed [FIN_W-1:0]  r_off_s8;
    logic signed [TEMP_W-1:0] r_temp_s8;

    // stage 9
    logic signed [Q_W-1:0] s9_q;
    logic signed [P_W-1:0] s9_p;
    logic                  t_lo, t_hi, p_lo, p_hi;
    logic [TOUT_W-1:0]     r_tout, n_tout;
    logic [POUT_W-1:0]     r_pout, n_pout;
    logic                  r_clamp, n_clamp;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // SENS split into an unsigned low part and a signed high part
    assign n_pl = PL_W'(i_d1) * PL_W'(i_so.sens[SPLIT-1:0]);
    assign n_ph = PH_W'($signed({1'b0, i_d1})) * PH_W'($signed(i_so.sens[FIN_W-1:SPLIT]));

    assign s8_hi   = PROD_W'($signed({r_ph, {SPLIT{1'b0}}}));
    assign s8_lo   = $signed(PROD_W'(r_pl));
    assign s8_prod = s8_hi + s8_lo;

    always_comb begin
        s9_q = Q_W'(r_q1) - Q_W'(r_off_s8);
        s9_p = $signed(s9_q[Q_W-1:Q_SH]);
        t_lo = r_temp_s8 < TEMP_W'(TEMP_MIN);
        t_hi = r_temp_s8 > TEMP_W'(TEMP_MAX);
        p_lo = s9_p[P_W-1];
        p_hi = s9_p > P_W'(PRES_MAX);
        priority if (t_lo) begin
            n_tout = TOUT_W'(TEMP_MIN);
        end else if (t_hi) begin
            n_tout = TOUT_W'(TEMP_MAX);
        end else begin
            n_tout = r_temp_s8[TOUT_W-1:0];
        end
        priority if (p_lo) begin
            n_pout = '0;
        end else if (p_hi) begin
            n_pout = POUT_W'(PRES_MAX);
        end else begin
            n_pout = s9_p[POUT_W-1:0];
        end
        n_clamp = t_lo || t_hi || p_lo || p_hi;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pl      <= n_pl;
            r_ph      <= n_ph;
            r_off_s7  <= i_so.off;
            r_temp_s7 <= i_so.temp;
        end
        if (en[1]) begin
            r_q1      <= s8_prod[PROD_W-1:P_SH];
            r_off_s8  <= r_off_s7;
            r_temp_s8 <= r_temp_s7;
        end
        if (en[2]) begin
            r_tout  <= n_tout;
            r_pout  <= n_pout;
            r_clamp <= n_clamp;
        end
    end

    assign o_temp  = r_tout;
    assign o_pres  = r_pout;
    assign o_clamp = r_clamp;

endmodule

`default_nettype wire

@@ design/baro_pressure_temp_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// barometer pressure and temperature compensation with second-order
// correction, as a nine-stage pipeline
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  ------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready   raw pressure, raw temp
//  m_axis    out        m_axis_tvalid/m_axis_tready   temp, pressure, clamped
//  cfg       in         i_cfg_valid/o_cfg_ready       index, 16-bit cal word
//
//  one transaction per cycle in and out while m_axis is not stalled; the
//  pipeline depth is set by the multiplier chain (dT products, squared
//  temperature terms, split 24 x 40 D1 * SENS product)
//  reset clears the valid bits of every stage and the calibration words
//  a stall at m_axis backs up stage by stage; empty stages still fill, so
//  bubbles are squeezed out and nothing is dropped or repeated
//  o_cfg_ready is always high; write calibration only while the pipe is idle
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation #(
    parameter int ADC_BITS = bptc_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [bptc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [14:0] temperature_centi, [31:15] pressure_centi
    output logic [bptc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] clamped
    output logic                                m_axis_tuser,
    // calibration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]          i_cfg_data
);
    import bptc_pkg::*;

    t_cal cal;

    // raw samples keep only their low ADC_BITS bits
    logic [ADC_BITS-1:0] in_d1;
    logic [ADC_BITS-1:0] in_d2;

    // first-order to second-order segment
    logic                fo_valid;
    logic                fo_ready;
    logic [ADC_BITS-1:0] fo_d1;
    t_fo                 fo;

    // second-order to pressure segment
    logic                so_valid;
    logic                so_ready;
    logic [ADC_BITS-1:0] so_d1;
    t_so                 so;

    logic [TOUT_W-1:0]   out_temp;
    logic [POUT_W-1:0]   out_pres;

    assign in_d1 = s_axis_tdata[ADC_BITS-1:0];
    assign in_d2 = s_axis_tdata[RAW_W+ADC_BITS-1:RAW_W];

    bptc_cal_regs u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cal   (cal)
    );

    // stages 1..3: dT, products with the calibration words, TEMP/OFF/SENS/T2
    bptc_first_order #(
        .ADC_BITS (ADC_BITS)
    ) u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_d1    (in_d1),
        .i_d2    (in_d2),
        .o_valid (fo_valid),
        .i_ready (fo_ready),
        .o_d1    (fo_d1),
        .o_fo    (fo)
    );

    // stages 4..6: below 20.00 C subtract T2, OFF2, SENS2
    bptc_second_order #(
        .ADC_BITS (ADC_BITS)
    ) u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fo_valid),
        .o_ready (fo_ready),
        .i_d1    (fo_d1),
        .i_fo    (fo),
        .o_valid (so_valid),
        .i_ready (so_ready),
        .o_d1    (so_d1),
        .o_so    (so)
    );

    // stages 7..9: pressure from D1 * SENS and OFF, then limiting; stage 9
    // is the output register
    bptc_pressure #(
        .ADC_BITS (ADC_BITS)
    ) u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (so_valid),
        .o_ready (so_ready),
        .i_d1    (so_d1),
        .i_so    (so),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_temp  (out_temp),
        .o_pres  (out_pres),
        .o_clamp (m_axis_tuser)
    );

    assign m_axis_tdata = {out_pres, out_temp};

endmodule

`default_nettype wire

@@ design/bptc_checker.sv @@
// ----------------------------------------------------------------------------
// bptc_checker
// port-level assertions for the compensation block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bptc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [bptc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tuser
);
    import bptc_pkg::*;

    // a waiting result holds still
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // temperature always inside the sensor range
    `ASSERT_IMPLIES(a_temp_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[TOUT_W-1:0]) >= $signed(TOUT_W'(TEMP_MIN))) && ($signed(m_axis_tdata[TOUT_W-1:0]) <= $signed(TOUT_W'(TEMP_MAX))))

    // pressure never above full scale
    `ASSERT_IMPLIES(a_pres_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:TOUT_W] <= POUT_W'(PRES_MAX))

    // input only backs up when the whole pipe is full down to the output
    `ASSERT_IMPLIES(a_stall_source, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
